// File: rtl/core/sip_pkg.sv
// Package with widths and types shared by the segment intersection files.
`timescale 1ns / 1ps
package sip_pkg;
   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS + 1;
   localparam int DEN_BITS   = 2 * COORD_BITS + 1;
   localparam int NUM_BITS   = DEN_BITS + COORD_BITS + 1;
   localparam int QUO_BITS   = NUM_BITS + FRAC_BITS;
   localparam int REQ_BYTES  = (8 * COORD_BITS + 7) / 8;
   localparam int RSP_BYTES  = (1 + 2 * OUT_BITS + 7) / 8;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [OUT_BITS-1:0]   fix_type;
endpackage

// File: rtl/core/sip_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sip_divider
   import sip_pkg::*;
(
   input  logic                clock,
   input  logic                advance,
   input  logic [QUO_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic [QUO_BITS-1:0] quotient
);
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS+1];
   logic [DEN_BITS:0]   rem_ff [QUO_BITS+1];
   logic [DEN_BITS-1:0] div_ff [QUO_BITS+1];

   always_comb begin
      quo_ff[0] = dividend;
      rem_ff[0] = '0;
      div_ff[0] = divisor;
   end

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
      logic [DEN_BITS+1:0] trial_in;
      logic [DEN_BITS:0]   rem_in;
      logic [QUO_BITS-1:0] quo_in;
      logic [QUO_BITS-1:0] q_reg_ff;
      logic [DEN_BITS:0]   r_reg_ff;
      logic [DEN_BITS-1:0] d_reg_ff;
      always_comb begin
         trial_in = {rem_ff[i], quo_ff[i][QUO_BITS-1]} - {2'b00, div_ff[i]};
         quo_in   = {quo_ff[i][QUO_BITS-2:0], ~trial_in[DEN_BITS+1]};
         if (trial_in[DEN_BITS+1]) begin
            rem_in = {rem_ff[i][DEN_BITS-1:0], quo_ff[i][QUO_BITS-1]};
         end else begin
            rem_in = trial_in[DEN_BITS:0];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            q_reg_ff <= quo_in;
            r_reg_ff <= rem_in;
            d_reg_ff <= div_ff[i];
         end
      end
      always_comb begin
         quo_ff[i+1] = q_reg_ff;
         rem_ff[i+1] = r_reg_ff;
         div_ff[i+1] = d_reg_ff;
      end
   end

   assign quotient = quo_ff[QUO_BITS];
endmodule

// File: rtl/core/segment_intersection_point_core.sv
// Top level of the segment intersection pipeline.
`timescale 1ns / 1ps
// Usage: one request word holds two segments AB and CD, eight 11-bit
// unsigned coordinates. One response word comes back per request, with a
// hit flag and the crossing point in 11.8 fixed point, or zeros.
// Throughput is one word per cycle while the receiver does not stall.
// There are 4 + 43 register stages: four arithmetic stages, then one
// divider stage per quotient bit (43 bits). The quotient width sets the depth.
// The whole pipeline advances together whenever the output register is
// empty or is being read; when the receiver stalls, every stage holds
// and req_tready falls, so no word is lost or repeated.
// Synchronous reset clears all valid bits; payload is not reset.
// Ports: req_tvalid/req_tready/req_tdata in, rsp_tvalid/rsp_tready/
// rsp_tdata out. Divider stages hold x and y numerators separately.
module segment_intersection_point_core
   import sip_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // ax, ay, bx, by, cx, cy, dx, dy from the lowest bit up.
   input  logic [8*REQ_BYTES-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // hit, cross_x, cross_y from the lowest bit up.
   output logic [8*RSP_BYTES-1:0] rsp_tdata
);
   localparam int DEPTH = 4 + QUO_BITS;

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   logic hit_ff [2:DEPTH-1];

   assign advance    = ~vld_ff[DEPTH-1] | rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   coord_type ax, ay, bx, by, cx, cy, dx, dy;
   assign {dy, dx, cy, cx, by, bx, ay, ax} = req_tdata[8*COORD_BITS-1:0];

   // Stage 1: differences.
   logic signed [DIFF_BITS-1:0] rx_ff, ry_ff, sx_ff, sy_ff, acx_ff, acy_ff;
   logic signed [DIFF_BITS-1:0] adx_ff, ady_ff, cbx_ff, cby_ff;
   coord_type ax1_ff, ay1_ff, bx1_ff, by1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff  <= $signed({1'b0, bx}) - $signed({1'b0, ax});
         ry_ff  <= $signed({1'b0, by}) - $signed({1'b0, ay});
         sx_ff  <= $signed({1'b0, dx}) - $signed({1'b0, cx});
         sy_ff  <= $signed({1'b0, dy}) - $signed({1'b0, cy});
         acx_ff <= $signed({1'b0, cx}) - $signed({1'b0, ax});
         acy_ff <= $signed({1'b0, cy}) - $signed({1'b0, ay});
         adx_ff <= $signed({1'b0, dx}) - $signed({1'b0, ax});
         ady_ff <= $signed({1'b0, dy}) - $signed({1'b0, ay});
         cbx_ff <= $signed({1'b0, bx}) - $signed({1'b0, cx});
         cby_ff <= $signed({1'b0, by}) - $signed({1'b0, cy});
         ax1_ff <= ax; ay1_ff <= ay; bx1_ff <= bx; by1_ff <= by;
      end
   end

   // Stage 2: products.
   // side C wrt AB: acx*ry - acy*rx ; side D: adx*ry - ady*rx
   // side A wrt CD: -acx*sy + acy*sx ; side B: cbx*sy - cby*sx
   // den = rx*sy - ry*sx ; tn = acx*sy - acy*sx (so side A = -tn)
   logic signed [PROD_BITS-1:0] p_ff [10];
   coord_type ax2_ff, ay2_ff, bx2_ff, by2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= PROD_BITS'(acx_ff * ry_ff);
         p_ff[1] <= PROD_BITS'(acy_ff * rx_ff);
         p_ff[2] <= PROD_BITS'(adx_ff * ry_ff);
         p_ff[3] <= PROD_BITS'(ady_ff * rx_ff);
         p_ff[4] <= PROD_BITS'(cbx_ff * sy_ff);
         p_ff[5] <= PROD_BITS'(cby_ff * sx_ff);
         p_ff[6] <= PROD_BITS'(rx_ff * sy_ff);
         p_ff[7] <= PROD_BITS'(ry_ff * sx_ff);
         p_ff[8] <= PROD_BITS'(acx_ff * sy_ff);
         p_ff[9] <= PROD_BITS'(acy_ff * sx_ff);
         ax2_ff <= ax1_ff; ay2_ff <= ay1_ff; bx2_ff <= bx1_ff; by2_ff <= by1_ff;
      end
   end

   // Stage 3: cross products, hit decision, normalised den, tn and den - tn.
   logic signed [PROD_BITS:0] vc, vd, vb, vden, vtn, den_abs, tn_abs;
   logic hit_in;
   always_comb begin
      vc   = {p_ff[0][PROD_BITS-1], p_ff[0]} - {p_ff[1][PROD_BITS-1], p_ff[1]};
      vd   = {p_ff[2][PROD_BITS-1], p_ff[2]} - {p_ff[3][PROD_BITS-1], p_ff[3]};
      vb   = {p_ff[4][PROD_BITS-1], p_ff[4]} - {p_ff[5][PROD_BITS-1], p_ff[5]};
      vden = {p_ff[6][PROD_BITS-1], p_ff[6]} - {p_ff[7][PROD_BITS-1], p_ff[7]};
      vtn  = {p_ff[8][PROD_BITS-1], p_ff[8]} - {p_ff[9][PROD_BITS-1], p_ff[9]};
      den_abs = vden[PROD_BITS] ? -vden : vden;
      tn_abs  = vden[PROD_BITS] ? -vtn : vtn;
      // Side of A is the negated tn; strict opposite signs required.
      hit_in = (vc != 0) && (vd != 0) && (vc[PROD_BITS] != vd[PROD_BITS])
             && (vtn != 0) && (vb != 0) && (vtn[PROD_BITS] == vb[PROD_BITS])
             && !tn_abs[PROD_BITS] && (tn_abs != 0) && (tn_abs < den_abs);
   end

   logic [DEN_BITS-1:0] den_ff, tn_ff, rem_ff;
   coord_type ax3_ff, ay3_ff, bx3_ff, by3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff[2] <= hit_in;
         den_ff <= DEN_BITS'(den_abs);
         tn_ff  <= DEN_BITS'(tn_abs);
         rem_ff <= DEN_BITS'(den_abs - tn_abs);
         ax3_ff <= ax2_ff; ay3_ff <= ay2_ff; bx3_ff <= bx2_ff; by3_ff <= by2_ff;
      end
   end

   // Stage 4: interpolation numerators and divisor (1 on a miss).
   logic [NUM_BITS-1:0] numx_ff, numy_ff;
   logic [DEN_BITS-1:0] den4_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff[3] <= hit_ff[2];
         numx_ff <= NUM_BITS'(ax3_ff * rem_ff) + NUM_BITS'(bx3_ff * tn_ff);
         numy_ff <= NUM_BITS'(ay3_ff * rem_ff) + NUM_BITS'(by3_ff * tn_ff);
         den4_ff <= hit_ff[2] ? den_ff : DEN_BITS'(1);
      end
   end

   logic [QUO_BITS-1:0] qx, qy;
   sip_divider u_divx (
      .clock(clock), .advance(advance),
      .dividend({numx_ff, {FRAC_BITS{1'b0}}}), .divisor(den4_ff), .quotient(qx));
   sip_divider u_divy (
      .clock(clock), .advance(advance),
      .dividend({numy_ff, {FRAC_BITS{1'b0}}}), .divisor(den4_ff), .quotient(qy));

   for (genvar i = 4; i < DEPTH; i++) begin : g_hit
      always_ff @(posedge clock) begin
         if (advance) begin
            hit_ff[i] <= hit_ff[i-1];
         end
      end
   end

   logic h;
   assign h = hit_ff[DEPTH-1];
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata = (8*RSP_BYTES)'({h ? OUT_BITS'(qy) : {OUT_BITS{1'b0}},
                                      h ? OUT_BITS'(qx) : {OUT_BITS{1'b0}}, h});
endmodule

// File: rtl/core/sip_checker.sv
// Port checker for the segment intersection core, bound to the top level.
`timescale 1ns / 1ps
module sip_checker
   import sip_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [8*REQ_BYTES-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [8*RSP_BYTES-1:0] rsp_tdata
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed under stall");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[2*OUT_BITS:1] == '0)
      else $error("miss carries a point");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("not ready with empty output");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind segment_intersection_point_core sip_checker u_sip_checker (.*);
